@@ rtl/mur_pkg.sv @@
// ----------------------------------------------------------------------------
// Multichannel ultrasonic ranger package
// Shared constants, command codes and the layout of one sensor entry.
// ----------------------------------------------------------------------------
package mur_pkg;

   // Sensor table size and the widths that follow from the field layout.
   localparam int MAX_SENSORS = 8;
   localparam int SENSOR_AW   = 3;
   localparam int COUNT_W     = 4;
   localparam int INTERVAL_W  = 16;
   localparam int LIMIT_W     = INTERVAL_W + COUNT_W;
   localparam int PULSE_W     = 20;
   localparam int TIME_W      = 32;
   localparam int DIST_W      = 13;
   localparam int CSR_W       = 16;

   // Command codes.
   localparam logic [1:0] CMD_TRIGGER = 2'd0;
   localparam logic [1:0] CMD_ECHO    = 2'd1;
   localparam logic [1:0] CMD_HEALTH  = 2'd2;

   // Register indexes.
   localparam logic CSR_SENSOR_COUNT = 1'b0;
   localparam logic CSR_INTERVAL_MS  = 1'b1;

   // Register reset values.
   localparam logic [COUNT_W-1:0]    SENSOR_COUNT_RESET = 4'd0;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET     = 16'd50;

   // Pulses longer than this are more than 399 cm and read as blocked.
   localparam logic [PULSE_W-1:0] BLOCK_PULSE_US = 20'd23142;

   // Distance is pulse * 16 / 58 = (pulse * 8) / 29. The divide by 29 is a
   // multiply by ceil(2^24 / 29) and a shift by 24, exact for pulse * 8 below
   // 2^24 / 9, which covers every unblocked pulse.
   localparam int SCALED_W    = 18;
   localparam int RECIP_W     = 20;
   localparam int PROD_W      = SCALED_W + RECIP_W;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_29 = 20'd578525;

   // One entry of the sensor memory.
   typedef struct packed {
      logic [DIST_W-1:0] previous;
      logic [DIST_W-1:0] distance;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/mur_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read word.
// ----------------------------------------------------------------------------
module mur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read word holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/multi_ultrasonic_ranger_core.sv @@
// ----------------------------------------------------------------------------
// Multichannel ultrasonic ranger core
// A trigger reduces the advanced index by the count; an echo runs EMUL (scaling
// multiply while the entry read completes) and EWB (write back); a health check
// reads each used sensor's entry. A trigger or health check with no sensors and a
// refused echo never go busy. The result word shows in the cycle after the last
// busy cycle with busy already low, so the next word can go in then; the receiver
// cannot stall. Reset clears the index and valid bits and resets the registers.
// ----------------------------------------------------------------------------
module multi_ultrasonic_ranger_core
   import mur_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [SENSOR_AW-1:0]  req_sensor_id,
   input  logic [PULSE_W-1:0]    req_pulse_us,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [SENSOR_AW-1:0]  rsp_fire_sensor,
   output logic                  rsp_fire_valid,
   output logic [DIST_W-1:0]     rsp_distance_sixteenths,
   output logic [DIST_W-1:0]     rsp_previous_sixteenths,
   output logic                  rsp_echo_accepted,
   output logic                  rsp_healthy
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TRIG = 3'd1;
   localparam logic [2:0] ST_EMUL = 3'd2;
   localparam logic [2:0] ST_EWB  = 3'd3;
   localparam logic [2:0] ST_HCHK = 3'd4;

   // Control and configuration registers.
   logic [2:0]            state_ff, state_in;
   logic [COUNT_W-1:0]    sensor_count_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [SENSOR_AW-1:0]  index_ff, index_in;
   logic [MAX_SENSORS-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Per-command working registers.
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    mod_ff, mod_in;
   logic [SENSOR_AW-1:0]  id_ff, id_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [SENSOR_AW-1:0]  walk_ff, walk_in;
   logic                  ok_ff, ok_in;
   logic                  rd_valid_ff;

   // Result word registers.
   logic [1:0]            kind_ff, kind_in;
   logic [SENSOR_AW-1:0]  fire_ff, fire_in;
   logic                  fire_valid_ff, fire_valid_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [DIST_W-1:0]     prev_ff, prev_in;
   logic                  echo_ok_ff, echo_ok_in;
   logic                  healthy_ff, healthy_in;

   // Memory ports.
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [SENSOR_AW-1:0]  ram_rd_addr;
   entry_type             wr_entry;
   entry_type             rd_entry;
   logic [ENTRY_W-1:0]    ram_rd_data;

   // Combinational helpers.
   logic                  accept;
   logic [COUNT_W-1:0]    active_count;
   logic [SCALED_W-1:0]   scaled;
   logic [DIST_W-1:0]     new_dist;
   logic [DIST_W-1:0]     old_dist;
   logic [TIME_W-1:0]     stamp;
   logic [TIME_W-1:0]     age;
   logic                  stale;
   logic [SENSOR_AW-1:0]  walk_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The count in use is capped at the memory depth.
   assign active_count = (sensor_count_ff > COUNT_W'(MAX_SENSORS)) ?
                         COUNT_W'(MAX_SENSORS) : sensor_count_ff;

   // Pulse scaling: blocked pulses give zero distance.
   assign scaled   = (pulse_ff > BLOCK_PULSE_US) ? '0 : {pulse_ff[SCALED_W-4:0], 3'b000};
   assign new_dist = prod_ff[RECIP_SHIFT +: DIST_W];

   // Fields of the entry read back; an entry never written reads as zero.
   assign rd_entry  = entry_type'(ram_rd_data);
   assign old_dist  = rd_valid_ff ? rd_entry.distance : '0;
   assign stamp     = rd_valid_ff ? rd_entry.stamp : '0;
   assign age       = now_ff - stamp;
   assign stale     = (age > TIME_W'(limit_ff));
   assign walk_next = walk_ff + SENSOR_AW'(1);

   assign wr_entry.previous = old_dist;
   assign wr_entry.distance = new_dist;
   assign wr_entry.stamp    = now_ff;

   mur_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SENSORS)
   ) u_sensor_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (id_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      index_in      = index_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      mod_in        = mod_ff;
      id_in         = id_ff;
      pulse_in      = pulse_ff;
      now_in        = now_ff;
      prod_in       = prod_ff;
      limit_in      = limit_ff;
      walk_in       = walk_ff;
      ok_in         = ok_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = walk_next;
      rsp_valid_in  = 1'b0;
      kind_in       = kind_ff;
      fire_in       = '0;
      fire_valid_in = 1'b0;
      dist_in       = '0;
      prev_in       = '0;
      echo_ok_in    = 1'b0;
      healthy_in    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = active_count;
               id_in    = req_sensor_id;
               pulse_in = req_pulse_us;
               now_in   = req_now_ms;
               kind_in  = req_command;
               case (req_command)
                  CMD_TRIGGER: begin
                     if (active_count == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mod_in   = {1'b0, index_ff} + COUNT_W'(1);
                        state_in = ST_TRIG;
                     end
                  end
                  CMD_ECHO: begin
                     if ({1'b0, req_sensor_id} >= active_count) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_sensor_id;
                        state_in    = ST_EMUL;
                     end
                  end
                  CMD_HEALTH: begin
                     limit_in = LIMIT_W'(interval_ff) * LIMIT_W'(active_count);
                     if (active_count == '0) begin
                        rsp_valid_in = 1'b1;
                        healthy_in   = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        walk_in     = '0;
                        ok_in       = 1'b1;
                        state_in    = ST_HCHK;
                     end
                  end
                  default: begin
                     // Reserved command: no result, no state change.
                  end
               endcase
            end
         end

         // Reduce the advanced index by the count, one subtract a cycle.
         ST_TRIG: begin
            if (mod_ff >= count_ff) begin
               mod_in = mod_ff - count_ff;
            end else begin
               index_in      = mod_ff[SENSOR_AW-1:0];
               fire_in       = mod_ff[SENSOR_AW-1:0];
               fire_valid_in = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         // Scale the pulse while the entry read completes.
         ST_EMUL: begin
            prod_in  = PROD_W'(scaled) * PROD_W'(RECIP_29);
            state_in = ST_EWB;
         end

         // Write the entry back with the shifted distance and the new stamp.
         ST_EWB: begin
            ram_wr_en       = 1'b1;
            valid_in[id_ff] = 1'b1;
            dist_in         = new_dist;
            prev_in         = old_dist;
            echo_ok_in      = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end

         // Check one stamp a cycle while the next entry is read.
         ST_HCHK: begin
            ok_in = ok_ff && !stale;
            if ({1'b0, walk_ff} + COUNT_W'(1) == count_ff) begin
               healthy_in   = ok_ff && !stale;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               walk_in   = walk_next;
               ram_rd_en = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         index_ff        <= '0;
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         sensor_count_ff <= SENSOR_COUNT_RESET;
         interval_ff     <= INTERVAL_RESET;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SENSOR_COUNT: sensor_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_INTERVAL_MS:  interval_ff     <= csr_wdata[INTERVAL_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Working and result word registers.
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      mod_ff        <= mod_in;
      id_ff         <= id_in;
      pulse_ff      <= pulse_in;
      now_ff        <= now_in;
      prod_ff       <= prod_in;
      limit_ff      <= limit_in;
      walk_ff       <= walk_in;
      ok_ff         <= ok_in;
      kind_ff       <= kind_in;
      fire_ff       <= fire_in;
      fire_valid_ff <= fire_valid_in;
      dist_ff       <= dist_in;
      prev_ff       <= prev_in;
      echo_ok_ff    <= echo_ok_in;
      healthy_ff    <= healthy_in;
      if (ram_rd_en) begin
         rd_valid_ff <= valid_ff[ram_rd_addr];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_kind                = kind_ff;
   assign rsp_fire_sensor         = fire_ff;
   assign rsp_fire_valid          = fire_valid_ff;
   assign rsp_distance_sixteenths = dist_ff;
   assign rsp_previous_sixteenths = prev_ff;
   assign rsp_echo_accepted       = echo_ok_ff;
   assign rsp_healthy             = healthy_ff;

   // A result word only appears once the sequencer is back at rest.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result word shown while a command is still in progress");

   // Every entry write is followed by an accepted echo result.
   a_wr_echo: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (rsp_valid_ff && echo_ok_ff && kind_ff == CMD_ECHO))
      else $error("entry written without an accepted echo result");

   // The health walk never runs past the sensors in use.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HCHK) |-> ({1'b0, walk_ff} < count_ff))
      else $error("health walk past the sensor count");

   // The wrap reduction starts from at most the memory depth.
   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIG) |-> (mod_ff <= COUNT_W'(MAX_SENSORS) && count_ff != '0))
      else $error("trigger reduction out of range");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Multichannel ultrasonic ranger core testbench
// Sends trigger, echo and health words through the start/busy port. A
// predictor keeps its own sensor table and registers, and works out the
// result for each accepted word. A checker compares every strobed result,
// field by field, with the oldest expected one. Directed tests cover the
// reset values, the round-robin wrap, the distance scaling and the stamp age
// limit. Random traffic then runs with several register settings and
// sender idle rates.
// ----------------------------------------------------------------------------
module testbench
   import mur_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Command 3 has no meaning and gives no result.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Longest command is a trigger that wraps.
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [1:0]           kind;
      logic [SENSOR_AW-1:0] fire_sensor;
      logic                 fire_valid;
      logic [DIST_W-1:0]    distance;
      logic [DIST_W-1:0]    previous;
      logic                 echo_accepted;
      logic                 healthy;
   } ranger_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_command = '0;
   logic [SENSOR_AW-1:0] req_sensor_id = '0;
   logic [PULSE_W-1:0]   req_pulse_us = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 csr_wr_en = 1'b0;
   logic                 csr_index = 1'b0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_kind;
   logic [SENSOR_AW-1:0] rsp_fire_sensor;
   logic                 rsp_fire_valid;
   logic [DIST_W-1:0]    rsp_distance_sixteenths;
   logic [DIST_W-1:0]    rsp_previous_sixteenths;
   logic                 rsp_echo_accepted;
   logic                 rsp_healthy;

   // Predictor copy of the registers and the sensor table.
   logic [COUNT_W-1:0]    sensor_count_reg;
   logic [INTERVAL_W-1:0] interval_reg;
   int unsigned           ring_index;
   logic [DIST_W-1:0]     distance_mem [MAX_SENSORS];
   logic [DIST_W-1:0]     previous_mem [MAX_SENSORS];
   logic [TIME_W-1:0]     stamp_mem [MAX_SENSORS];

   ranger_result_type  expected_results [$];
   int unsigned     mismatch_count = 0;
   logic [TIME_W-1:0] now_base;

   multi_ultrasonic_ranger_core DUT (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_command             (req_command),
      .req_sensor_id           (req_sensor_id),
      .req_pulse_us            (req_pulse_us),
      .req_now_ms              (req_now_ms),
      .csr_wr_en               (csr_wr_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .rsp_valid               (rsp_valid),
      .rsp_kind                (rsp_kind),
      .rsp_fire_sensor         (rsp_fire_sensor),
      .rsp_fire_valid          (rsp_fire_valid),
      .rsp_distance_sixteenths (rsp_distance_sixteenths),
      .rsp_previous_sixteenths (rsp_previous_sixteenths),
      .rsp_echo_accepted       (rsp_echo_accepted),
      .rsp_healthy             (rsp_healthy)
   );

   always #5 clock = ~clock;

   // Hard limit on the run in case the block stops answering.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH at %0t ns: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // Sensors in use, limited to the table size.
   function automatic int unsigned sensors_in_use();
      return (sensor_count_reg > MAX_SENSORS) ? MAX_SENSORS : sensor_count_reg;
   endfunction

   function automatic void clear_ranger_state();
      sensor_count_reg = SENSOR_COUNT_RESET;
      interval_reg = INTERVAL_RESET;
      ring_index = 0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
         distance_mem[i] = '0;
         previous_mem[i] = '0;
         stamp_mem[i] = '0;
      end
   endfunction

   // Works out the result of one word and updates the sensor table.
   // Returns 0 when the word gives no result.
   function automatic bit predict_ranger(input logic [1:0] cmd,
                                         input logic [SENSOR_AW-1:0] id,
                                         input logic [PULSE_W-1:0] pulse,
                                         input logic [TIME_W-1:0] now,
                                         output ranger_result_type r);
      int unsigned n;
      logic [31:0] dist_value;
      logic [31:0] limit;
      logic [31:0] age;
      n = sensors_in_use();
      r = '0;
      if (cmd == CMD_UNUSED) return 1'b0;
      r.kind = cmd;
      case (cmd)
         CMD_TRIGGER: begin
            if (n != 0) begin
               ring_index = (ring_index + 1) % n;
               r.fire_sensor = SENSOR_AW'(ring_index);
               r.fire_valid = 1'b1;
            end
         end
         CMD_ECHO: begin
            if (id < n) begin
               // Pulse to 1/16 cm, zero when the echo is too long.
               if (pulse > BLOCK_PULSE_US) dist_value = 0;
               else dist_value = ({12'd0, pulse} * 32'd16) / 32'd58;
               previous_mem[id] = distance_mem[id];
               distance_mem[id] = dist_value[DIST_W-1:0];
               stamp_mem[id] = now;
               r.distance = dist_value[DIST_W-1:0];
               r.previous = previous_mem[id];
               r.echo_accepted = 1'b1;
            end
         end
         default: begin
            limit = 32'(interval_reg) * n;
            r.healthy = 1'b1;
            for (int i = 0; i < n; i++) begin
               age = now - stamp_mem[i];
               if (age > limit) r.healthy = 1'b0;
            end
         end
      endcase
      return 1'b1;
   endfunction

   // Compares each strobed result with the oldest expected one.
   always @(posedge clock) begin : result_checker
      ranger_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(rsp_kind), 32'(want.kind));
            check_field("fire_sensor", 32'(rsp_fire_sensor), 32'(want.fire_sensor));
            check_field("fire_valid", 32'(rsp_fire_valid), 32'(want.fire_valid));
            check_field("distance", 32'(rsp_distance_sixteenths), 32'(want.distance));
            check_field("previous", 32'(rsp_previous_sixteenths), 32'(want.previous));
            check_field("echo_accepted", 32'(rsp_echo_accepted),
                        32'(want.echo_accepted));
            check_field("healthy", 32'(rsp_healthy), 32'(want.healthy));
         end
      end
   end

   // Offers one word and returns at the edge that accepts it. Start stays
   // high so that a following word can go out back to back.
   task automatic send_word(input logic [1:0] cmd, input logic [SENSOR_AW-1:0] id,
                            input logic [PULSE_W-1:0] pulse,
                            input logic [TIME_W-1:0] now);
      ranger_result_type want;
      start <= 1'b1;
      req_command <= cmd;
      req_sensor_id <= id;
      req_pulse_us <= pulse;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_ranger(cmd, id, pulse, now, want)) begin
         expected_results = {expected_results, want};
      end
   endtask

   task automatic sender_pause(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Waits until every result is in and the block has gone quiet.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SENSOR_COUNT) sensor_count_reg = value[COUNT_W-1:0];
      else interval_reg = value;
      @(posedge clock);
   endtask

   // Reset values: no sensors, so triggers do nothing, echoes are refused
   // and the health check passes.
   task automatic test_idle_defaults();
      send_word(CMD_TRIGGER, 3'd0, 20'd0, 32'd0);
      send_word(CMD_ECHO, 3'd0, 20'hFFFFF, 32'hFFFF_FFFF);
      send_word(CMD_HEALTH, 3'd7, 20'd0, 32'd0);
      send_word(CMD_UNUSED, 3'd7, 20'hFFFFF, 32'hFFFF_FFFF);
      drain_results();
   endtask

   // Round-robin wrap, a count above the table size, and an index left
   // past the count after the count is lowered.
   task automatic test_round_robin();
      write_register(CSR_SENSOR_COUNT, 16'd3);
      write_register(CSR_INTERVAL_MS, 16'd1);
      repeat (4) send_word(CMD_TRIGGER, 3'd0, 20'd0, 32'd0);
      drain_results();
      write_register(CSR_SENSOR_COUNT, 16'hFFFF);
      repeat (3) send_word(CMD_TRIGGER, 3'd7, 20'hFFFFF, 32'hFFFF_FFFF);
      drain_results();
      write_register(CSR_SENSOR_COUNT, 16'd2);
      send_word(CMD_TRIGGER, 3'd0, 20'd0, 32'd0);
      drain_results();
   endtask

   // Distance scaling at zero, at the blocking edge and beyond it, and an
   // echo from a sensor outside the count.
   task automatic test_echo_distance();
      write_register(CSR_SENSOR_COUNT, 16'd8);
      write_register(CSR_INTERVAL_MS, 16'hFFFF);
      send_word(CMD_ECHO, 3'd7, 20'd0, 32'd100);
      send_word(CMD_ECHO, 3'd7, BLOCK_PULSE_US, 32'd200);
      send_word(CMD_ECHO, 3'd0, BLOCK_PULSE_US + 20'd1, 32'd300);
      send_word(CMD_ECHO, 3'd1, 20'hFFFFF, 32'd400);
      send_word(CMD_ECHO, 3'd2, 20'd58, 32'd500);
      drain_results();
      write_register(CSR_SENSOR_COUNT, 16'd5);
      send_word(CMD_ECHO, 3'd5, 20'd58, 32'd600);
      drain_results();
   endtask

   // Stamp age across the time wrap, exactly at the limit and one past it.
   task automatic test_stamp_age();
      write_register(CSR_SENSOR_COUNT, 16'd2);
      write_register(CSR_INTERVAL_MS, 16'd10);
      send_word(CMD_ECHO, 3'd0, 20'd100, 32'hFFFF_FFF0);
      send_word(CMD_ECHO, 3'd1, 20'd200, 32'hFFFF_FFF8);
      send_word(CMD_HEALTH, 3'd0, 20'd0, 32'd4);
      send_word(CMD_HEALTH, 3'd0, 20'd0, 32'd5);
      drain_results();
   endtask

   // New random register setting, extremes included.
   task automatic randomize_registers();
      logic [COUNT_W-1:0] count;
      logic [CSR_W-1:0]   interval;
      case ($urandom_range(9))
         0: count = 4'd0;
         1: count = 4'd1;
         2: count = 4'd15;
         3: count = 4'($urandom_range(9, 15));
         default: count = 4'($urandom_range(2, 8));
      endcase
      case ($urandom_range(5))
         0: interval = 16'd1;
         1: interval = 16'hFFFF;
         2, 3: interval = 16'($urandom_range(1, 65535));
         default: interval = 16'($urandom_range(1, 100));
      endcase
      write_register(CSR_SENSOR_COUNT, {12'($urandom_range(0, 4095)), count});
      write_register(CSR_INTERVAL_MS, interval);
   endtask

   // Random traffic: mostly well-formed echoes near the running time and
   // health checks near the age limit, with some noise words.
   task automatic test_random_traffic(input int unsigned items,
                                      input int unsigned idle_pct);
      int unsigned done_items;
      int unsigned block_left;
      int unsigned burst_left;
      int unsigned n;
      int unsigned sel;
      int unsigned k;
      logic [1:0]           cmd;
      logic [SENSOR_AW-1:0] id;
      logic [PULSE_W-1:0]   pulse;
      logic [TIME_W-1:0]    now;
      done_items = 0;
      block_left = 0;
      burst_left = 0;
      now_base = $urandom;
      while (done_items < items) begin
         if (block_left == 0) begin
            drain_results();
            randomize_registers();
            block_left = 40;
         end
         n = sensors_in_use();
         sel = $urandom_range(99);
         cmd = 2'($urandom_range(3));
         id = 3'($urandom_range(7));
         pulse = 20'($urandom_range(0, 20'hFFFFF));
         now = $urandom;
         if (sel < 5) begin
            // Noise: every field random.
         end else if (sel < 9) begin
            cmd = CMD_UNUSED;
         end else if (sel < 38) begin
            cmd = CMD_TRIGGER;
         end else if (sel < 72) begin
            cmd = CMD_ECHO;
            if (n != 0 && $urandom_range(99) < 85) id = 3'($urandom_range(0, n - 1));
            k = $urandom_range(99);
            if (k < 60) pulse = 20'($urandom_range(0, BLOCK_PULSE_US));
            else if (k < 75) pulse = 20'($urandom_range(23100, 23200));
            now = now_base;
         end else begin
            cmd = CMD_HEALTH;
            k = $urandom_range(9);
            if (k < 5) begin
               now = now_base;
            end else if (k < 9 && n != 0) begin
               // Right at the age limit of one sensor, give or take one.
               now = stamp_mem[$urandom_range(0, n - 1)] + 32'(interval_reg) * n
                     + 32'($urandom_range(0, 2)) - 32'd1;
            end
         end
         send_word(cmd, id, pulse, now);
         if (cmd != CMD_UNUSED) begin
            done_items++;
            block_left--;
         end
         // Let time run on, with an occasional jump anywhere.
         if ($urandom_range(49) == 0) now_base = $urandom;
         else now_base = now_base + $urandom_range(0, interval_reg);
         if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(99) < 8) begin
            burst_left = $urandom_range(8, 20);
         end else if ($urandom_range(99) < idle_pct) begin
            sender_pause($urandom_range(1, 12));
         end
      end
      drain_results();
   endtask

   initial begin
      clear_ranger_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_defaults();
      test_round_robin();
      test_echo_distance();
      test_stamp_age();
      test_random_traffic(240, 0);
      test_random_traffic(230, 52);
      test_random_traffic(230, 19);
      drain_results();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
